// ===== rtl/kscd_pkg.sv =====
// Shared types, constants and keymap tables for the keyboard scan-code decoder.
package kscd_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;
    localparam int WAITING_W        = 9;
    localparam int ASCII_W          = 7;
    localparam int CODE_W           = 8;
    localparam int CMDQ_DEPTH       = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [7:0] KEY_RELEASE = 8'h80;
    localparam logic [7:0] KEY_MASK    = 8'h7f;
    localparam logic [6:0] KEY_LSHIFT  = 7'h2a;
    localparam logic [6:0] KEY_RSHIFT  = 7'h36;
    localparam logic [6:0] KEY_CAPS    = 7'h3a;
    localparam logic [6:0] MAP_SIZE    = 7'd54;

    localparam logic [ASCII_W-1:0] MAP_PLAIN [0:53] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
        7'h00, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
        7'h6d, 7'h2c, 7'h2e, 7'h2f
    };

    localparam logic [ASCII_W-1:0] MAP_SHIFT [0:53] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
        7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3b,
        7'h00, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
        7'h4d, 7'h3c, 7'h3e, 7'h3f
    };

    typedef struct packed {
        logic                 taken;
        logic                 dropped;
        logic [CODE_W-1:0]    code;
        logic [WAITING_W-1:0] waiting;
    } t_cmd;

    typedef struct packed {
        logic [ASCII_W-1:0]   ascii;
        logic                 taken;
        logic                 dropped;
        logic [WAITING_W-1:0] waiting;
    } t_result;

endpackage

// ===== rtl/kscd_front.sv =====
// Front end: scan-code ring buffer, pointers and fill count; emits one command per beat.
module kscd_front #(
    parameter int BUFFER_DEPTH = kscd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_operation,
    input  logic [kscd_pkg::CODE_W-1:0]  i_scancode,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_ready,
    output kscd_pkg::t_cmd               o_cmd
);

    localparam int PTR_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(BUFFER_DEPTH);

    logic [kscd_pkg::CODE_W-1:0] r_store [0:BUFFER_DEPTH-1];

    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_pend, n_pend;
    logic              r_taken;
    logic              r_dropped;
    logic [kscd_pkg::WAITING_W-1:0] r_waiting;
    logic [kscd_pkg::CODE_W-1:0]    r_rd_data;

    logic accept;
    logic wr_en;
    logic rd_en;

    // A new beat may enter while the pending command leaves in the same cycle.
    assign o_full = r_pend && !i_cmd_ready;
    assign accept = i_push && !o_full;
    assign wr_en  = accept && (i_operation == kscd_pkg::OP_PUSH) && (r_fill != FULL_FILL);
    assign rd_en  = accept && (i_operation == kscd_pkg::OP_POP) && (r_fill != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            n_fill   = r_fill + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            n_fill   = r_fill - 1'b1;
        end
        if (accept) begin
            n_pend = 1'b1;
        end else if (r_pend && i_cmd_ready) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_taken   <= rd_en;
            r_dropped <= (i_operation == kscd_pkg::OP_PUSH) && !wr_en;
            r_waiting <= kscd_pkg::WAITING_W'(n_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_wr_ptr] <= i_scancode;
        end
        if (rd_en) begin
            r_rd_data <= r_store[r_rd_ptr];
        end
    end

    assign o_cmd_valid     = r_pend;
    assign o_cmd.taken     = r_taken;
    assign o_cmd.dropped   = r_dropped;
    assign o_cmd.code      = r_taken ? r_rd_data : '0;
    assign o_cmd.waiting   = r_waiting;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_FILL)
        else $error("fill count beyond buffer depth");

    a_drop_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == kscd_pkg::OP_PUSH) && (r_fill == FULL_FILL))
        |=> (r_dropped && !r_taken && $stable(r_fill)))
        else $error("push into full buffer not flagged as dropped");
`endif

endmodule

// ===== rtl/kscd_cmdq.sv =====
// Short command queue between the front end and the decoder.
module kscd_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  kscd_pkg::t_cmd i_wr_cmd,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output kscd_pkg::t_cmd o_rd_cmd
);

    localparam int PTR_W = (kscd_pkg::CMDQ_DEPTH > 1) ? $clog2(kscd_pkg::CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(kscd_pkg::CMDQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(kscd_pkg::CMDQ_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(kscd_pkg::CMDQ_DEPTH);

    kscd_pkg::t_cmd r_mem [0:kscd_pkg::CMDQ_DEPTH-1];

    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             wr_fire;
    logic             rd_fire;

    assign o_wr_ready = (r_cnt != FULL_CNT);
    assign o_rd_valid = (r_cnt != '0);
    assign wr_fire    = i_wr_valid && o_wr_ready;
    assign rd_fire    = o_rd_valid && i_rd_ready;
    assign o_rd_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_fire) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_fire) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

// ===== rtl/kscd_back.sv =====
// Back end: set-1 decoding with shift and caps state, and the result register.
module kscd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  kscd_pkg::t_cmd    i_cmd,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output kscd_pkg::t_result o_res
);

    logic r_caps, n_caps;
    logic r_shifted, n_shifted;
    logic r_out_valid, n_out_valid;
    kscd_pkg::t_result r_res;

    logic                         fire;
    logic [6:0]                   key;
    logic                         is_shift;
    logic                         is_release;
    logic [kscd_pkg::ASCII_W-1:0] ascii;

    assign o_cmd_ready = !r_out_valid || i_res_ready;
    assign fire        = i_cmd_valid && o_cmd_ready;
    assign key         = 7'(i_cmd.code & kscd_pkg::KEY_MASK);
    assign is_release  = (i_cmd.code & kscd_pkg::KEY_RELEASE) != '0;
    assign is_shift    = (key == kscd_pkg::KEY_LSHIFT) || (key == kscd_pkg::KEY_RSHIFT);

    always_comb begin
        n_caps    = r_caps;
        n_shifted = r_shifted;
        ascii     = '0;
        if (i_cmd.taken) begin
            if (is_release) begin
                // Only a shift release matters: fall back to the caps-lock map.
                if (is_shift) begin
                    n_shifted = r_caps;
                end
            end else if (key == kscd_pkg::KEY_CAPS) begin
                n_caps    = !r_caps;
                n_shifted = !r_shifted;
            end else if (is_shift) begin
                n_shifted = !r_caps;
            end else if (key < kscd_pkg::MAP_SIZE) begin
                ascii = r_shifted ? kscd_pkg::MAP_SHIFT[key[5:0]]
                                  : kscd_pkg::MAP_PLAIN[key[5:0]];
            end
        end
    end

    always_comb begin
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caps      <= 1'b0;
            r_shifted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (fire) begin
                r_caps    <= n_caps;
                r_shifted <= n_shifted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res.ascii   <= ascii;
            r_res.taken   <= i_cmd.taken;
            r_res.dropped <= i_cmd.dropped;
            r_res.waiting <= i_cmd.waiting;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

`ifndef ASSERT_OFF
    a_state_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !i_cmd.taken) |=> ($stable(r_caps) && $stable(r_shifted)))
        else $error("keymap state changed without a popped code");

    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("decoded beat did not reach the result register");

    a_char_needs_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.ascii != '0)) |-> (r_res.taken && !r_res.dropped))
        else $error("character reported without a popped code");
`endif

endmodule

// ===== rtl/keyboard_scancode_fifo_decoder.sv =====
// Top level of the keyboard scan-code buffer with set-1 to ASCII decoding.
//
//  Channel  | Ports                                      | Beat taken when
//  ---------+--------------------------------------------+------------------
//  item in  | i_operation, i_scancode                    | push && !full
//  result   | o_ascii_char, o_code_taken, o_push_dropped,| pop && !empty
//           | o_codes_waiting                            |
//
// Up to one item per cycle while full is low; the scan-code store has one
// write and one read port, and each item uses at most one of them in its
// accept cycle. A result passes the front stage, command queue and result register.
// full rises only when the command queue and the front stage are both held
// by a stalled result side. Synchronous active-low reset, no clearing pass.
module keyboard_scancode_fifo_decoder #(
    parameter int BUFFER_DEPTH = kscd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_operation,
    input  logic [kscd_pkg::CODE_W-1:0]     i_scancode,
    output logic                            empty,
    input  logic                            pop,
    output logic [kscd_pkg::ASCII_W-1:0]    o_ascii_char,
    output logic                            o_code_taken,
    output logic                            o_push_dropped,
    output logic [kscd_pkg::WAITING_W-1:0]  o_codes_waiting
);

    kscd_pkg::t_cmd    front_cmd;
    kscd_pkg::t_cmd    back_cmd;
    kscd_pkg::t_result res;
    logic              front_valid;
    logic              front_ready;
    logic              back_valid;
    logic              back_ready;
    logic              res_valid;

    kscd_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_operation (i_operation),
        .i_scancode  (i_scancode),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    kscd_cmdq u_cmdq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_cmd   (front_cmd),
        .o_rd_valid (back_valid),
        .i_rd_ready (back_ready),
        .o_rd_cmd   (back_cmd)
    );

    kscd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .i_cmd       (back_cmd),
        .o_res_valid (res_valid),
        .i_res_ready (pop),
        .o_res       (res)
    );

    assign empty           = !res_valid;
    assign o_ascii_char    = res.ascii;
    assign o_code_taken    = res.taken;
    assign o_push_dropped  = res.dropped;
    assign o_codes_waiting = res.waiting;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the keyboard scan-code buffer with set-1 to ASCII decoding.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 10;
    localparam int DEPTH      = kscd_pkg::BUFFER_DEPTH_DEF;
    localparam int HOLD_AT    = 200;
    localparam int HOLD_LEN   = 300;
    localparam int SETTLE     = 10;

    typedef struct packed {
        logic              op;
        logic [7:0]        code;
        logic              typed;
        kscd_pkg::t_result want;
    } t_script_row;

    localparam kscd_pkg::t_result NO_RESULT = '0;

    localparam logic [6:0] PLAIN_KEYS [54] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
        7'h00, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
        7'h6d, 7'h2c, 7'h2e, 7'h2f
    };

    localparam logic [6:0] SHIFT_KEYS [54] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
        7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3b,
        7'h00, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
        7'h4d, 7'h3c, 7'h3e, 7'h3f
    };

    // Typed rows: pop on an empty buffer, the first pushes, and the final pops.
    localparam t_script_row SCRIPT [24] = '{
        '{kscd_pkg::OP_POP,  8'h00, 1'b1, '{7'h00, 1'b0, 1'b0, 9'd0}},
        '{kscd_pkg::OP_PUSH, 8'h00, 1'b1, '{7'h00, 1'b0, 1'b0, 9'd1}},
        '{kscd_pkg::OP_PUSH, 8'hff, 1'b1, '{7'h00, 1'b0, 1'b0, 9'd2}},
        '{kscd_pkg::OP_PUSH, 8'h2a, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_PUSH, 8'h1e, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_PUSH, 8'haa, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_PUSH, 8'h3a, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_PUSH, 8'h1e, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_PUSH, 8'h36, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_PUSH, 8'h35, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_PUSH, 8'hb6, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_PUSH, 8'h7f, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_POP,  8'hff, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_POP,  8'h00, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_POP,  8'h55, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_POP,  8'haa, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_POP,  8'h00, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_POP,  8'h00, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_POP,  8'h00, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_POP,  8'h00, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_POP,  8'h00, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_POP,  8'h00, 1'b0, NO_RESULT},
        '{kscd_pkg::OP_POP,  8'h00, 1'b1, '{7'h00, 1'b1, 1'b0, 9'd0}},
        '{kscd_pkg::OP_POP,  8'h00, 1'b1, '{7'h00, 1'b0, 1'b0, 9'd0}}
    };

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                push        = 1'b0;
    logic                                pop         = 1'b0;
    logic                                i_operation = kscd_pkg::OP_PUSH;
    logic [kscd_pkg::CODE_W-1:0]         i_scancode  = '0;
    logic                                full;
    logic                                empty;
    logic [kscd_pkg::ASCII_W-1:0]        o_ascii_char;
    logic                                o_code_taken;
    logic                                o_push_dropped;
    logic [kscd_pkg::WAITING_W-1:0]      o_codes_waiting;

    // Shadow of the scan-code buffer and the keymap state.
    logic [7:0]   code_mem [DEPTH];
    int unsigned  wr_idx    = 0;
    int unsigned  rd_idx    = 0;
    int unsigned  fill      = 0;
    logic         caps_lock = 1'b0;
    logic         shift_map = 1'b0;

    kscd_pkg::t_result key_results_due [$];
    int                errors    = 0;
    int                send_calm = 0;
    int                recv_calm = 0;

    keyboard_scancode_fifo_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_operation     (i_operation),
        .i_scancode      (i_scancode),
        .empty           (empty),
        .pop             (pop),
        .o_ascii_char    (o_ascii_char),
        .o_code_taken    (o_code_taken),
        .o_push_dropped  (o_push_dropped),
        .o_codes_waiting (o_codes_waiting)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic kscd_pkg::t_result decode_step(logic op, logic [7:0] code);
        kscd_pkg::t_result r;
        logic [7:0]        raw;
        logic [6:0]        key;
        logic              is_shift;
        r = '0;
        if (op == kscd_pkg::OP_PUSH) begin
            if (fill >= DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                code_mem[wr_idx] = code;
                wr_idx = (wr_idx + 1) % DEPTH;
                fill++;
            end
        end else if (fill != 0) begin
            raw = code_mem[rd_idx];
            rd_idx = (rd_idx + 1) % DEPTH;
            fill--;
            r.taken = 1'b1;
            key = raw[6:0];
            is_shift = (key == kscd_pkg::KEY_LSHIFT) || (key == kscd_pkg::KEY_RSHIFT);
            if ((raw & kscd_pkg::KEY_RELEASE) != 0) begin
                // Only a shift release matters: fall back to the caps lock map.
                if (is_shift) begin
                    shift_map = caps_lock;
                end
            end else if (key == kscd_pkg::KEY_CAPS) begin
                caps_lock = !caps_lock;
                shift_map = !shift_map;
            end else if (is_shift) begin
                shift_map = !caps_lock;
            end else if (key < kscd_pkg::MAP_SIZE) begin
                r.ascii = shift_map ? SHIFT_KEYS[key] : PLAIN_KEYS[key];
            end
        end
        r.waiting = kscd_pkg::WAITING_W'(fill);
        return r;
    endfunction

    // Idle cycles before the next beat, with occasional stretches of none.
    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(10, 40);
        end
        return $urandom_range(0, 4);
    endfunction

    // Mostly realistic key traffic, the rest any byte at all.
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 9)) inside
            [0:4]:   return 8'($urandom_range(0, 53));
            5:       return {1'b0, ($urandom_range(0, 1) != 0) ? kscd_pkg::KEY_LSHIFT
                                                               : kscd_pkg::KEY_RSHIFT};
            6:       return kscd_pkg::KEY_RELEASE |
                            {1'b0, ($urandom_range(0, 1) != 0) ? kscd_pkg::KEY_LSHIFT
                                                               : kscd_pkg::KEY_RSHIFT};
            7:       return ($urandom_range(0, 1) != 0)
                            ? {1'b0, kscd_pkg::KEY_CAPS}
                            : (kscd_pkg::KEY_RELEASE | {1'b0, kscd_pkg::KEY_CAPS});
            8:       return kscd_pkg::KEY_RELEASE | 8'($urandom_range(0, 53));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(logic op, logic [7:0] code, logic typed,
                             kscd_pkg::t_result want);
        int                gap;
        kscd_pkg::t_result due;
        gap = draw_idle(send_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_operation <= op;
        i_scancode  <= code;
        do begin
            @(posedge i_clk);
        end while (full);
        due = decode_step(op, code);
        key_results_due.push_back(typed ? want : due);
    endtask

    task automatic send_random(int pop_pct);
        if ($urandom_range(1, 100) <= pop_pct) begin
            send_item(kscd_pkg::OP_POP, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
        end else begin
            send_item(kscd_pkg::OP_PUSH, pick_code(), 1'b0, NO_RESULT);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (key_results_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic void compare_field(string name, logic [8:0] want, logic [8:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic check_beat(kscd_pkg::t_result got);
        kscd_pkg::t_result want;
        if (key_results_due.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = key_results_due.pop_front();
        compare_field("ascii_char", 9'(want.ascii), 9'(got.ascii));
        compare_field("code_taken", 9'(want.taken), 9'(got.taken));
        compare_field("push_dropped", 9'(want.dropped), 9'(got.dropped));
        compare_field("codes_waiting", want.waiting, got.waiting);
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < $size(SCRIPT); i++) begin
            send_item(SCRIPT[i].op, SCRIPT[i].code, SCRIPT[i].typed, SCRIPT[i].want);
        end
        wait_drained();
        repeat (100) send_random(fill > 20 ? 60 : 40);
        // Run the buffer past capacity so the last pushes are dropped.
        repeat (DEPTH + 2) send_item(kscd_pkg::OP_PUSH, pick_code(), 1'b0, NO_RESULT);
        while (fill != 0) send_random(85);
        send_item(kscd_pkg::OP_POP, 8'h00, 1'b0, NO_RESULT);
        wait_drained();
        repeat (100) send_random(fill > 20 ? 60 : 40);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : receiver
        int                gap;
        int                beats;
        kscd_pkg::t_result got;
        beats = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_idle(recv_calm);
            // One long hold-off lets the block fill up and push back on the sender.
            if (beats == HOLD_AT) begin
                gap = HOLD_LEN;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (empty);
            got.ascii   = o_ascii_char;
            got.taken   = o_code_taken;
            got.dropped = o_push_dropped;
            got.waiting = o_codes_waiting;
            check_beat(got);
            beats++;
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
